FILE: rtl/aem_pkg.sv
// Shared types and constants for the audio echo mixer.
// Word formats, register indexes and controller/datapath interface structs.
// No dependencies.
package aem_pkg;

  // Delay line geometry
  localparam int MAX_DELAY = 8192;
  localparam int ADDR_W    = $clog2(MAX_DELAY);
  localparam int DLY_W     = $clog2(MAX_DELAY + 1);

  // Field widths
  localparam int SMP_W     = 16;
  localparam int DELAY_W   = 14;
  localparam int DIVISOR_W = 15;
  localparam int TAIL_W    = 14;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 15;
  localparam int DIV_CNT_W = $clog2(SMP_W);

  localparam logic [TAIL_W-1:0]    TAIL_MAX          = '1;
  localparam logic [DELAY_W-1:0]   ECHO_DELAY_RST    = 14'd8000;
  localparam logic [DIVISOR_W-1:0] ECHO_DIVISOR_RST  = 15'd4;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_DELAY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_DIVISOR = 2'd1;

  // Input word
  typedef struct packed {
    logic                    func;
    logic signed [SMP_W-1:0] sample_in;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [SMP_W-1:0] mixed_sample;
    logic                    drain_finished;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic mem_step;
    logic div_load;
    logic div_step;
    logic out_load;
  } aem_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
    logic out_free;
  } aem_status_t;

endpackage

FILE: rtl/aem_ctrl.sv
// Sequencer of the audio echo mixer: capture, delay line access, divide, output.
// Depends on aem_pkg.
module aem_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  aem_pkg::aem_status_t status,
  output aem_pkg::aem_cmd_t    cmd
);
  import aem_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        cmd.mem_step = 1'b1;
        state_nxt    = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/aem_datapath.sv
// Datapath of the audio echo mixer: config registers, delay line memory,
// serial divider and output register. Depends on aem_pkg.
module aem_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  aem_pkg::aem_cmd_t              cmd,
  output aem_pkg::aem_status_t           status,
  input  aem_pkg::in_word_t              in_word,
  input  logic                           cfg_valid,
  input  logic [aem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aem_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  output logic                           out_valid,
  input  logic                           out_ready,
  output aem_pkg::out_word_t             out_word
);
  import aem_pkg::*;

  // Configuration
  logic [DELAY_W-1:0]   echo_delay_r;
  logic [DIVISOR_W-1:0] echo_divisor_r;

  // Stream state
  logic [ADDR_W-1:0] wp_r;
  logic              wrapped_r;
  logic [TAIL_W-1:0] tail_r;

  // Per-word registers
  logic signed [SMP_W-1:0] x_r;
  logic                    tail_step_r;
  logic [ADDR_W-1:0]       rd_r;
  logic                    rd_valid_r;
  logic [DLY_W-1:0]        d_r;
  logic [DIVISOR_W-1:0]    div_r;
  logic [SMP_W-1:0]        rdata_r;
  logic                    flag_r;

  // Divider
  logic [SMP_W-1:0]     q_r;
  logic [DIVISOR_W-1:0] rem_r;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  // Output register
  logic      out_valid_r;
  out_word_t out_word_r;

  logic [SMP_W-1:0]        delay_mem [MAX_DELAY];

  logic [DLY_W-1:0]        d_eff;
  logic [DLY_W-1:0]        wp_ext;
  logic [ADDR_W-1:0]       rd_nxt;
  logic [DIVISOR_W-1:0]    div_eff;
  logic signed [SMP_W-1:0] delayed;
  logic [SMP_W-1:0]        trial;
  logic                    ge;
  logic [SMP_W-1:0]        diff;
  logic [SMP_W-1:0]        echo;
  logic [TAIL_W-1:0]       tail_nxt;

  // Clamp delay and divisor, form the read address behind the write pointer
  always_comb begin
    if (echo_delay_r == '0) begin
      d_eff = DLY_W'(1);
    end else if (32'(echo_delay_r) > MAX_DELAY) begin
      d_eff = DLY_W'(MAX_DELAY);
    end else begin
      d_eff = DLY_W'(echo_delay_r);
    end
    div_eff = (echo_divisor_r == '0) ? DIVISOR_W'(1) : echo_divisor_r;
    wp_ext  = DLY_W'(wp_r);
    if (wp_ext >= d_eff) begin
      rd_nxt = ADDR_W'(wp_ext - d_eff);
    end else begin
      rd_nxt = ADDR_W'(wp_ext + DLY_W'(MAX_DELAY) - d_eff);
    end
  end

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_delay_r   <= ECHO_DELAY_RST;
      echo_divisor_r <= ECHO_DIVISOR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ECHO_DELAY:   echo_delay_r   <= cfg_wdata[DELAY_W-1:0];
        REG_ECHO_DIVISOR: echo_divisor_r <= cfg_wdata[DIVISOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the word; an entry is history only if written since reset
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r         <= in_word.func ? '0 : in_word.sample_in;
      tail_step_r <= in_word.func;
      rd_r        <= rd_nxt;
      rd_valid_r  <= wrapped_r || (rd_nxt < wp_r);
      d_r         <= d_eff;
      div_r       <= div_eff;
    end
  end

  // Delay line: read old sample, store new one
  always_ff @(posedge clk) begin
    if (cmd.mem_step) begin
      rdata_r        <= delay_mem[rd_r];
      delay_mem[wp_r] <= x_r;
    end
  end

  assign tail_nxt = (tail_r < TAIL_MAX) ? tail_r + TAIL_W'(1) : tail_r;

  // Advance write pointer and tail counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
      tail_r    <= '0;
    end else if (cmd.mem_step) begin
      if (wp_r == ADDR_W'(MAX_DELAY - 1)) begin
        wp_r      <= '0;
        wrapped_r <= 1'b1;
      end else begin
        wp_r <= wp_r + ADDR_W'(1);
      end
      tail_r <= tail_step_r ? tail_nxt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_step) begin
      flag_r <= tail_step_r && (32'(tail_nxt) == 32'(d_r));
    end
  end

  // Restoring divide step on the magnitude
  assign delayed = rd_valid_r ? rdata_r : '0;
  assign trial   = {rem_r, q_r[SMP_W-1]};
  assign ge      = trial >= SMP_W'(div_r);
  assign diff    = trial - SMP_W'(div_r);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg_r <= delayed[SMP_W-1];
      q_r   <= delayed[SMP_W-1] ? -delayed : delayed;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      q_r   <= {q_r[SMP_W-2:0], ge};
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  assign status.div_last = (cnt_r == DIV_CNT_W'(SMP_W - 1));
  assign status.out_free = !out_valid_r || out_ready;

  // Restore sign; the sum wraps to the sample width
  assign echo = neg_r ? -q_r : q_r;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word_r.mixed_sample   <= x_r + echo;
      out_word_r.drain_finished <= flag_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: rtl/audio_echo_mixer.sv
// Channel    | direction | handshake            | payload
// in_        | in        | in_valid / in_ready  | in_word (func, sample_in)
// out_       | out       | out_valid / out_ready| out_word (mixed_sample, drain_finished)
// cfg_       | in        | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// Each word passes through capture, delay line access, divider load,
// 16 steps of the one-bit-per-cycle divider, and output load once the output register is free.
// A finished result waits in the output register while the next word is taken.
// Reset clears the pointer; history never written since reset reads as zero.
// cfg_ready is always high. Top level of the audio echo mixer; depends on
// aem_pkg, aem_ctrl and aem_datapath.
module audio_echo_mixer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  aem_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output aem_pkg::out_word_t            out_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [aem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aem_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import aem_pkg::*;

  aem_cmd_t    cmd;
  aem_status_t status;

  assign cfg_ready = 1'b1;

  aem_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  aem_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_word   (in_word),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

FILE: rtl/aem_checker.sv
// Port-level checks for the audio echo mixer, bound to the top level.
// Depends on aem_pkg.
module aem_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input aem_pkg::out_word_t out_word,
  input logic               out_valid,
  input logic               out_ready
);
  import aem_pkg::*;

  // Stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled result changed");

  // One word at a time: busy right after a word is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word taken while busy");

  // No result appears the cycle after a word is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");

  // Reset empties the output
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind audio_echo_mixer aem_checker u_aem_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_word  (out_word),
  .out_valid (out_valid),
  .out_ready (out_ready)
);
